// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files, used by the tokenizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/qtt_pkg.sv -----
// types, codes and character constants of the quoted text tokenizer
package qtt_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned EvW   = 3;
  localparam int unsigned ClsW  = 4;
  localparam int unsigned NRes  = 3;
  localparam int unsigned CntW  = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [EvW-1:0]   ev_t;
  typedef logic [ClsW-1:0]  cls_t;
  typedef logic [CntW-1:0]  cnt_t;

  localparam ev_t EV_BYTE  = 3'd0;
  localparam ev_t EV_DONE  = 3'd1;
  localparam ev_t EV_ERROR = 3'd2;
  localparam ev_t EV_END   = 3'd3;
  localparam ev_t EV_EMPTY = 3'd4;

  localparam cls_t CL_WORD    = 4'd0;
  localparam cls_t CL_NUMBER  = 4'd1;
  localparam cls_t CL_UNKNOWN = 4'd2;
  localparam cls_t CL_BRACE   = 4'd3;
  localparam cls_t CL_BRACKET = 4'd4;
  localparam cls_t CL_COLON   = 4'd5;
  localparam cls_t CL_SEMI    = 4'd6;
  localparam cls_t CL_COMMA   = 4'd7;
  localparam cls_t CL_DOT     = 4'd8;
  localparam cls_t CL_SQ      = 4'd9;
  localparam cls_t CL_DQ      = 4'd10;

  localparam byte_t CH_NUL     = 8'h00;
  localparam byte_t CH_LBRACE  = 8'h7B;
  localparam byte_t CH_RBRACE  = 8'h7D;
  localparam byte_t CH_LBRACK  = 8'h5B;
  localparam byte_t CH_RBRACK  = 8'h5D;
  localparam byte_t CH_COLON   = 8'h3A;
  localparam byte_t CH_SEMI    = 8'h3B;
  localparam byte_t CH_COMMA   = 8'h2C;
  localparam byte_t CH_DOT     = 8'h2E;
  localparam byte_t CH_SQUOTE  = 8'h27;
  localparam byte_t CH_DQUOTE  = 8'h22;
  localparam byte_t CH_SPACE   = 8'h20;
  localparam byte_t CH_NEWLINE = 8'h0A;

  typedef struct packed {
    ev_t   ev;
    cls_t  cls;
    byte_t data;
  } tok_t;

  // all results caused by one text word
  typedef struct packed {
    cnt_t             cnt;
    tok_t [NRes-1:0]  res;
  } step_t;

endpackage

// ----- rtl/qtt_if.sv -----
// handshake channels: text words in, token words out
interface qtt_byte_if;
  import qtt_pkg::*;

  logic  valid;
  logic  ready;
  byte_t text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface qtt_tok_if;
  import qtt_pkg::*;

  logic  valid;
  logic  ready;
  ev_t   event_res;
  cls_t  token_class;
  byte_t byte_out;
  logic  last;

  modport source (output valid, output event_res, output token_class, output byte_out,
                  output last, input ready);
  modport sink (input valid, input event_res, input token_class, input byte_out,
                input last, output ready);
endinterface

// ----- rtl/qtt_parse.sv -----
// input register, tokenizer state and the per-word step logic
module qtt_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  qtt_byte_if.sink        in_i,
  input  logic            free_i,
  output qtt_pkg::step_t  step_o,
  output logic            load_o
);
  import qtt_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_QUOTE = 2'd2
  } mode_e;

  logic  in_valid_q;
  byte_t byte_q;
  mode_e mode_q, mode_d;
  logic  quote_kind_q, quote_kind_d;
  cls_t  run_class_q, run_class_d;
  logic  at_start_q, at_start_d;

  logic  advance;
  logic  do_idle;
  cnt_t  n;
  cls_t  svc;
  logic  is_sep, is_quote;
  byte_t quote_ch;

  function automatic cls_t svc_class(byte_t c);
    cls_t r;
    case (c)
      CH_LBRACE, CH_RBRACE: r = CL_BRACE;
      CH_LBRACK, CH_RBRACK: r = CL_BRACKET;
      CH_COLON:             r = CL_COLON;
      CH_SEMI:              r = CL_SEMI;
      CH_COMMA:             r = CL_COMMA;
      CH_DOT:               r = CL_DOT;
      default:              r = CL_WORD;
    endcase
    return r;
  endfunction

  function automatic cls_t start_class(byte_t c);
    cls_t r;
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
      r = CL_WORD;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = CL_NUMBER;
    end else begin
      r = CL_UNKNOWN;
    end
    return r;
  endfunction

  function automatic tok_t mk_tok(ev_t ev, cls_t cls, byte_t d);
    tok_t t;
    t.ev   = ev;
    t.cls  = cls;
    t.data = (ev == EV_BYTE) ? d : '0;
    return t;
  endfunction

  assign in_i.ready = !in_valid_q || free_i;
  assign advance    = in_valid_q && free_i;
  assign load_o     = advance && (step_o.cnt != '0);

  assign svc      = svc_class(byte_q);
  assign is_sep   = (byte_q == CH_SPACE) || (byte_q == CH_NEWLINE);
  assign is_quote = (byte_q == CH_SQUOTE) || (byte_q == CH_DQUOTE);
  assign quote_ch = quote_kind_q ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    mode_d       = mode_q;
    quote_kind_d = quote_kind_q;
    run_class_d  = run_class_q;
    at_start_d   = at_start_q;
    step_o       = '0;
    n            = '0;
    do_idle      = 1'b0;

    if (byte_q == CH_NUL) begin
      if (at_start_q) begin
        step_o.res[n] = mk_tok(EV_EMPTY, CL_WORD, CH_NUL);
        n = n + 2'd1;
      end else begin
        if (mode_q == MODE_RUN) begin
          step_o.res[n] = mk_tok(EV_DONE, run_class_q, CH_NUL);
          n = n + 2'd1;
        end else if (mode_q == MODE_QUOTE) begin
          step_o.res[n] = mk_tok(EV_ERROR, run_class_q, CH_NUL);
          n = n + 2'd1;
        end
        step_o.res[n] = mk_tok(EV_END, CL_WORD, CH_NUL);
        n = n + 2'd1;
      end
      mode_d       = MODE_IDLE;
      quote_kind_d = 1'b0;
      run_class_d  = CL_WORD;
      at_start_d   = 1'b1;
    end else begin
      at_start_d = 1'b0;
      case (mode_q)
        MODE_QUOTE: begin
          if (byte_q == quote_ch) begin
            step_o.res[n] = mk_tok(EV_DONE, run_class_q, CH_NUL);
            n = n + 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            step_o.res[n] = mk_tok(EV_BYTE, run_class_q, byte_q);
            n = n + 2'd1;
          end
        end
        MODE_RUN: begin
          if (is_sep || is_quote || (svc != CL_WORD)) begin
            step_o.res[n] = mk_tok(EV_DONE, run_class_q, CH_NUL);
            n = n + 2'd1;
            mode_d  = MODE_IDLE;
            do_idle = !is_sep;
          end else begin
            step_o.res[n] = mk_tok(EV_BYTE, run_class_q, byte_q);
            n = n + 2'd1;
          end
        end
        default: begin
          mode_d  = MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase

      // handling of a byte seen between tokens
      if (do_idle && !is_sep) begin
        if (is_quote) begin
          mode_d       = MODE_QUOTE;
          quote_kind_d = (byte_q == CH_DQUOTE);
          run_class_d  = (byte_q == CH_DQUOTE) ? CL_DQ : CL_SQ;
        end else if (svc != CL_WORD) begin
          step_o.res[n] = mk_tok(EV_BYTE, svc, byte_q);
          n = n + 2'd1;
          step_o.res[n] = mk_tok(EV_DONE, svc, CH_NUL);
          n = n + 2'd1;
        end else begin
          run_class_d   = start_class(byte_q);
          mode_d        = MODE_RUN;
          step_o.res[n] = mk_tok(EV_BYTE, start_class(byte_q), byte_q);
          n = n + 2'd1;
        end
      end
    end
    step_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      mode_q       <= MODE_IDLE;
      quote_kind_q <= 1'b0;
      run_class_q  <= CL_WORD;
      at_start_q   <= 1'b1;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        mode_q       <= mode_d;
        quote_kind_q <= quote_kind_d;
        run_class_q  <= run_class_d;
        at_start_q   <= at_start_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
    end
  end

endmodule

// ----- rtl/qtt_res_buf.sv -----
// result register holding up to three token words, drained one per cycle while out_o.ready is high
module qtt_res_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  qtt_pkg::step_t step_i,
  output logic           free_o,
  qtt_tok_if.source      out_o
);
  import qtt_pkg::*;

  logic            valid_q;
  cnt_t            cnt_q;
  cnt_t            idx_q;
  tok_t [NRes-1:0] res_q;
  tok_t            cur;
  logic            is_last;

  assign cur     = res_q[idx_q];
  assign is_last = (idx_q == (cnt_q - 2'd1));
  // room for a new set once the final word of the current one leaves
  assign free_o  = !valid_q || (out_o.ready && is_last);

  assign out_o.valid       = valid_q;
  assign out_o.event_res   = cur.ev;
  assign out_o.token_class = cur.cls;
  assign out_o.byte_out    = cur.data;
  assign out_o.last        = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      cnt_q   <= step_i.cnt;
      idx_q   <= '0;
    end else if (valid_q && out_o.ready) begin
      if (is_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= step_i.res;
    end
  end

endmodule

// ----- rtl/quoted_text_tokenizer.sv -----
// Streaming tokenizer for quoted text, one text byte per word.
//
// in_i carries text bytes; a NUL byte ends the message. out_o carries token
// words: byte, complete, unterminated quote error, end and empty events, each
// with a token class, the text byte for byte events and last set on the final
// word caused by one input byte.
// An input byte waits in the input register; its words are formed by the
// step logic and loaded into the result register once that register frees,
// and the first word is then valid on out_o. Throughput is one byte per cycle
// while the receiver is ready and each byte gives at most one word. A byte
// that gives two or three words holds the result register until its final
// word is taken, and input is held meanwhile. Bytes that give no word (spaces,
// opening quotes) load nothing, but still wait until the result register frees.
// When the receiver stalls, the current word holds and one more byte can wait
// in the input register before in_i.ready drops.
// Reset empties both registers and puts the tokenizer between tokens at the
// start of a message.
`include "assert_macros.svh"

module quoted_text_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  qtt_byte_if.sink   in_i,
  qtt_tok_if.source  out_o
);
  import qtt_pkg::*;

  step_t step;
  logic  load;
  logic  free;
  logic  end_word;
  logic  err_word;
  logic  ctl_word;

  qtt_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .free_i (free),
    .step_o (step),
    .load_o (load)
  );

  qtt_res_buf u_res_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .step_i (step),
    .free_o (free),
    .out_o  (out_o)
  );

  assign end_word = out_o.valid &&
                    (out_o.event_res == EV_END || out_o.event_res == EV_EMPTY);
  assign err_word = out_o.valid && (out_o.event_res == EV_ERROR);
  assign ctl_word = out_o.valid && (out_o.event_res != EV_BYTE);

  `ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |=> !out_o.valid, "word valid after reset")
  `ASSERT_RST(a_end_is_last, clk_i, rst_ni, end_word |-> out_o.last, "end or empty not final")
  `ASSERT_RST(a_error_not_last, clk_i, rst_ni, err_word |-> !out_o.last, "error without end")
  `ASSERT_RST(a_byte_zero, clk_i, rst_ni, ctl_word |-> (out_o.byte_out == '0), "stray text byte")

endmodule

// ----- dv/qtt_checker.sv -----
// checker for the quoted text tokenizer: predicts token words from accepted text words
module qtt_checker (
  input  logic clk_i,
  input  logic rst_ni,
  qtt_byte_if  text_i,
  qtt_tok_if   tok_i,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import qtt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_QUOTE = 2'd2
  } scan_mode_e;

  typedef struct packed {
    tok_t tok;
    logic last;
  } tok_word_t;

  scan_mode_e mode_q;
  logic       dq_q;
  cls_t       run_cls_q;
  logic       msg_start_q;

  tok_word_t  tok_exp_q[$];
  tok_word_t  step_q[$];
  int         fail_cnt;
  int         word_idx;

  function automatic void emit(ev_t ev, cls_t cls, byte_t b);
    tok_word_t w;
    w.tok.ev   = ev;
    w.tok.cls  = cls;
    w.tok.data = (ev == EV_BYTE) ? b : '0;
    w.last     = 1'b0;
    step_q = {step_q, w};
  endfunction

  function automatic logic is_sep(byte_t c);
    return (c == CH_SPACE) || (c == CH_NEWLINE);
  endfunction

  function automatic logic is_quote(byte_t c);
    return (c == CH_SQUOTE) || (c == CH_DQUOTE);
  endfunction

  function automatic logic punct(input byte_t c, output cls_t cls);
    cls = CL_WORD;
    case (c)
      CH_LBRACE, CH_RBRACE: cls = CL_BRACE;
      CH_LBRACK, CH_RBRACK: cls = CL_BRACKET;
      CH_COLON:             cls = CL_COLON;
      CH_SEMI:              cls = CL_SEMI;
      CH_COMMA:             cls = CL_COMMA;
      CH_DOT:               cls = CL_DOT;
      default:              return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void scan_idle(byte_t c);
    cls_t pc;
    if (is_sep(c)) return;
    if (is_quote(c)) begin
      mode_q    = ST_QUOTE;
      dq_q      = (c == CH_DQUOTE);
      run_cls_q = dq_q ? CL_DQ : CL_SQ;
      return;
    end
    if (punct(c, pc)) begin
      emit(EV_BYTE, pc, c);
      emit(EV_DONE, pc, '0);
      return;
    end
    // ascii-only classing by the first byte of the run
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
      run_cls_q = CL_WORD;
    end else if (c >= "0" && c <= "9") begin
      run_cls_q = CL_NUMBER;
    end else begin
      run_cls_q = CL_UNKNOWN;
    end
    mode_q = ST_RUN;
    emit(EV_BYTE, run_cls_q, c);
  endfunction

  function automatic void scan_byte(byte_t c);
    cls_t pc;
    if (c == CH_NUL) begin
      if (msg_start_q) begin
        emit(EV_EMPTY, CL_WORD, '0);
      end else begin
        if (mode_q == ST_RUN) begin
          emit(EV_DONE, run_cls_q, '0);
        end else if (mode_q == ST_QUOTE) begin
          emit(EV_ERROR, run_cls_q, '0);
        end
        emit(EV_END, CL_WORD, '0);
      end
      mode_q      = ST_IDLE;
      dq_q        = 1'b0;
      run_cls_q   = CL_WORD;
      msg_start_q = 1'b1;
      return;
    end
    msg_start_q = 1'b0;
    case (mode_q)
      ST_QUOTE: begin
        if (c == (dq_q ? CH_DQUOTE : CH_SQUOTE)) begin
          emit(EV_DONE, run_cls_q, '0);
          mode_q = ST_IDLE;
        end else begin
          emit(EV_BYTE, run_cls_q, c);
        end
      end
      ST_RUN: begin
        if (is_sep(c)) begin
          emit(EV_DONE, run_cls_q, '0);
          mode_q = ST_IDLE;
        end else if (is_quote(c) || punct(c, pc)) begin
          // run ends, then the byte starts afresh
          emit(EV_DONE, run_cls_q, '0);
          mode_q = ST_IDLE;
          scan_idle(c);
        end else begin
          emit(EV_BYTE, run_cls_q, c);
        end
      end
      default: begin
        mode_q = ST_IDLE;
        scan_idle(c);
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tok_word_t exp_w;
    tok_word_t got_w;
    if (!rst_ni) begin
      mode_q      = ST_IDLE;
      dq_q        = 1'b0;
      run_cls_q   = CL_WORD;
      msg_start_q = 1'b1;
      tok_exp_q.delete();
      fail_cnt    = 0;
      word_idx    = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        got_w.tok.ev   = tok_i.event_res;
        got_w.tok.cls  = tok_i.token_class;
        got_w.tok.data = tok_i.byte_out;
        got_w.last     = tok_i.last;
        if (tok_exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("token word %0d with nothing expected: ev=%0d cls=%0d byte=%02h last=%0b",
                     word_idx, got_w.tok.ev, got_w.tok.cls, got_w.tok.data, got_w.last);
          end
        end else begin
          exp_w = tok_exp_q.pop_front();
          if (got_w !== exp_w) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("token word %0d mismatch: exp ev=%0d cls=%0d byte=%02h last=%0b",
                       word_idx, exp_w.tok.ev, exp_w.tok.cls, exp_w.tok.data, exp_w.last);
              $display("                          got ev=%0d cls=%0d byte=%02h last=%0b",
                       got_w.tok.ev, got_w.tok.cls, got_w.tok.data, got_w.last);
            end
          end
        end
        word_idx++;
      end
      if (text_i.valid && text_i.ready) begin
        step_q.delete();
        scan_byte(text_i.text_byte);
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        tok_exp_q = {tok_exp_q, step_q};
      end
      pending_o  <= tok_exp_q.size();
      fail_cnt_o <= fail_cnt;
    end
  end

endmodule

// ----- dv/tb_quoted_text_tokenizer.sv -----
// testbench top for the quoted text tokenizer: clock, reset, text stimulus and verdict
module tb_quoted_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;
  import qtt_pkg::*;

  localparam int RandItems   = 100;
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 20;
  localparam int CycleLimit  = 200000;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_COMB} rx_phase_e;
  typedef enum {K_WORD, K_NUMBER, K_OTHER, K_PUNCT, K_QUOTED} tok_kind_e;

  // an empty message, one of each service byte, then runs, quotes and both message endings
  localparam byte_t Directed[25] = '{
    CH_NUL,
    CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_SEMI, CH_COMMA, CH_DOT,
    "a", "Z", CH_COMMA,
    "7", CH_SPACE,
    8'hFF, CH_DQUOTE, "q", CH_DQUOTE,
    CH_SQUOTE, CH_SQUOTE,
    CH_SQUOTE, 8'h80, CH_NUL,
    "z", CH_NUL
  };

  localparam byte_t PunctSet[8] = '{
    CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_SEMI, CH_COMMA, CH_DOT
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  qtt_byte_if text_if ();
  qtt_tok_if  tok_if ();

  int    fail_cnt;
  int    pending;
  int    cycle_cnt = 0;
  int    hold_req = 0;
  int    burst_left = 0;
  int    rand_items = 0;
  logic  count_on = 1'b0;
  byte_t msg_q[$];

  quoted_text_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (tok_if)
  );

  qtt_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_i     (text_if),
    .tok_i      (tok_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("** quoted_text_tokenizer: FAILED **");
      $finish;
    end
  end

  // offer one text word, in bursts with random gaps
  task automatic send_text(byte_t b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        text_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    text_if.valid     <= 1'b1;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
    if (count_on) rand_items++;
  endtask

  task automatic wait_drained();
    text_if.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic void add_byte(byte_t b);
    msg_q = {msg_q, b};
  endfunction

  // any byte that continues a run
  function automatic byte_t run_char();
    byte_t c;
    do begin
      c = byte_t'($urandom_range(1, 255));
    end while (c inside {CH_SPACE, CH_NEWLINE, CH_SQUOTE, CH_DQUOTE, CH_LBRACE, CH_RBRACE,
                         CH_LBRACK, CH_RBRACK, CH_COLON, CH_SEMI, CH_COMMA, CH_DOT});
    return c;
  endfunction

  function automatic void build_msg();
    int        ntok;
    tok_kind_e kind;
    byte_t     q;
    byte_t     c;
    msg_q.delete();
    if ($urandom_range(0, 6) == 0) begin
      // noise: raw bytes, nul included
      repeat ($urandom_range(1, 6)) add_byte(byte_t'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) add_byte(CH_NUL);
      return;
    end
    ntok = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    for (int i = 0; i < ntok; i++) begin
      kind = tok_kind_e'($urandom_range(0, 4));
      case (kind)
        K_WORD: begin
          c = byte_t'($urandom_range(0, 25)) + (($urandom_range(0, 1) == 0) ? "a" : "A");
          add_byte(c);
          repeat ($urandom_range(0, 4)) add_byte(run_char());
        end
        K_NUMBER: begin
          repeat ($urandom_range(1, 4)) add_byte(byte_t'($urandom_range(0, 9)) + "0");
        end
        K_OTHER: begin
          do c = run_char(); while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                                    (c >= "0" && c <= "9"));
          add_byte(c);
          repeat ($urandom_range(0, 3)) add_byte(run_char());
        end
        K_PUNCT: add_byte(PunctSet[$urandom_range(0, 7)]);
        default: begin
          q = ($urandom_range(0, 1) == 0) ? CH_SQUOTE : CH_DQUOTE;
          add_byte(q);
          repeat ($urandom_range(0, 5)) begin
            do c = byte_t'($urandom_range(1, 255)); while (c == q);
            add_byte(c);
          end
          // now and then the quote runs into the end of the message
          if (i == ntok - 1 && $urandom_range(0, 4) == 0) break;
          add_byte(q);
        end
      endcase
      case ($urandom_range(0, 3))
        0: ;
        1: add_byte(CH_SPACE);
        2: add_byte(CH_NEWLINE);
        default: begin
          add_byte(CH_SPACE);
          add_byte(CH_NEWLINE);
        end
      endcase
    end
    add_byte(CH_NUL);
  endfunction

  // receiver: ready pattern in phases, plus the long hold-off on request
  initial begin
    rx_phase_e phase;
    int        phase_left;
    int        holds_done;
    phase      = RX_OPEN;
    phase_left = 0;
    holds_done = 0;
    tok_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        tok_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (phase_left == 0) begin
          phase      = rx_phase_e'($urandom_range(0, 3));
          phase_left = $urandom_range(10, 60);
        end
        phase_left--;
        case (phase)
          RX_OPEN:   tok_if.ready <= 1'b1;
          RX_MOSTLY: tok_if.ready <= ($urandom_range(0, 3) != 0);
          RX_SPARSE: tok_if.ready <= ($urandom_range(0, 3) == 0);
          default:   tok_if.ready <= (phase_left % 3 != 0);
        endcase
      end
    end
  end

  initial begin
    text_if.valid     <= 1'b0;
    text_if.text_byte <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    count_on = 1'b1;
    foreach (Directed[i]) send_text(Directed[i]);
    wait_drained();

    for (int m = 0; rand_items < RandItems; m++) begin
      build_msg();
      if (m == 2) hold_req++;
      if (m == 5) wait_drained();
      foreach (msg_q[i]) send_text(msg_q[i]);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("** quoted_text_tokenizer: PASSED **");
    end else begin
      $display("** quoted_text_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
